@@ hw/rtl/dem_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// dem_pkg
// Constants shared by the decimal-exponent modular power block.
// ---------------------------------------------------------------------------
package dem_pkg;

  localparam int unsigned MODULUS   = 1337;
  // Internal residue width follows the modulus
  localparam int unsigned RES_W     = $clog2(MODULUS);
  // Fixed field widths of the stream and config payloads
  localparam int unsigned BASE_W    = 31;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned RESIDUE_W = 11;
  localparam int unsigned S_DATA_W  = 8;
  localparam int unsigned M_DATA_W  = 16;
  // r^10 from r takes nine further products
  localparam int unsigned SQ_COUNT  = 9;

endpackage

`default_nettype wire

@@ hw/rtl/decimal_exponent_modpow.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// decimal_exponent_modpow
// Modular power a^E mod MODULUS with E streamed as decimal digits.
// ---------------------------------------------------------------------------
// Each input item carries one exponent digit d (most significant first); the
// block updates the running residue r to r^10 * a^d mod MODULUS and returns
// one output item with the new residue, tlast marking the final digit, after
// which r returns to 1. All products run on a single bit-serial modular
// multiplier that consumes one multiplier bit per cycle: nine products by r,
// then d products by the base, after which the result waits until the output
// register is free, and the next item can be accepted once it is loaded there.
// A write to base_value while idle or reducing reduces the base modulo MODULUS
// one bit per cycle, holding s_axis_tready_o low during the write and the
// reduction after it. The next item is accepted while a finished result still
// waits in the output register.
module decimal_exponent_modpow (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration: base_value
  input  wire logic                         cfg_we_i,
  input  wire logic [dem_pkg::BASE_W-1:0]   cfg_wdata_i,
  // Input stream
  input  wire logic                         s_axis_tvalid_i,
  output      logic                         s_axis_tready_o,
  input  wire logic [dem_pkg::S_DATA_W-1:0] s_axis_tdata_i,  // [3:0] digit, rest zero
  input  wire logic                         s_axis_tlast_i,  // final digit flag
  // Output stream
  output      logic                         m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output      logic [dem_pkg::M_DATA_W-1:0] m_axis_tdata_o,  // [10:0] residue, rest zero
  output      logic                         m_axis_tlast_o   // final_res
);

  localparam int unsigned RW    = dem_pkg::RES_W;
  localparam int unsigned CNT_W = $clog2(RW + 1);
  localparam int unsigned BW    = dem_pkg::BASE_W;
  localparam int unsigned BCN_W = $clog2(BW + 1);
  localparam logic [RW:0]   MOD_X   = (RW + 1)'(dem_pkg::MODULUS);
  localparam logic [RW-1:0] ONE_R   = RW'(1);
  localparam logic [3:0]    SQ_INIT = 4'(dem_pkg::SQ_COUNT);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RED  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [RW-1:0]    run_q, run_d;       // running residue
  logic [RW-1:0]    base_q, base_d;     // a mod MODULUS
  logic [BW-1:0]    bsh_q, bsh_d;       // base bits still to reduce
  logic [BCN_W-1:0] bcnt_q, bcnt_d;
  logic [RW-1:0]    acc_q, acc_d;       // product chain value
  logic [RW-1:0]    prod_q, prod_d;     // partial product
  logic [RW-1:0]    shf_q, shf_d;       // multiplier bits, MSB first
  logic [CNT_W-1:0] bit_q, bit_d;
  logic [3:0]       sq_q, sq_d;         // r products left
  logic [3:0]       dl_q, dl_d;         // a products left
  logic             last_q, last_d;
  logic             ov_q, ov_d;
  logic [RW-1:0]    ores_q, ores_d;
  logic             olast_q, olast_d;

  logic             s_acc;
  logic [RW-1:0]    mcand;
  logic [RW:0]      dbl, sum;
  logic [RW-1:0]    dbl_r, step;
  logic [RW:0]      bdbl;
  logic [RW-1:0]    bstep;
  logic [3:0]       sq_n, dl_n;

  // Take items only when idle, and hold them off while the base is being written
  assign s_axis_tready_o = (state_q == ST_IDLE) && !cfg_we_i;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = dem_pkg::M_DATA_W'(dem_pkg::RESIDUE_W'(ores_q));
  assign m_axis_tlast_o  = olast_q;

  // One bit of acc * mcand mod MODULUS: double, then add on a set bit
  assign mcand = (sq_q != 4'd0) ? run_q : base_q;
  assign dbl   = {prod_q, 1'b0};
  assign dbl_r = (dbl >= MOD_X) ? RW'(dbl - MOD_X) : dbl[RW-1:0];
  assign sum   = {1'b0, dbl_r} + (shf_q[RW-1] ? {1'b0, mcand} : '0);
  assign step  = (sum >= MOD_X) ? RW'(sum - MOD_X) : sum[RW-1:0];

  // One bit of base reduction, Horner form
  assign bdbl  = {base_q, bsh_q[BW-1]};
  assign bstep = (bdbl >= MOD_X) ? RW'(bdbl - MOD_X) : bdbl[RW-1:0];

  assign sq_n = (sq_q != 4'd0) ? sq_q - 4'd1 : sq_q;
  assign dl_n = (sq_q != 4'd0) ? dl_q : dl_q - 4'd1;

  always_comb begin
    state_d = state_q;
    run_d   = run_q;
    base_d  = base_q;
    bsh_d   = bsh_q;
    bcnt_d  = bcnt_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    shf_d   = shf_q;
    bit_d   = bit_q;
    sq_d    = sq_q;
    dl_d    = dl_q;
    last_d  = last_q;
    ov_d    = ov_q;
    ores_d  = ores_q;
    olast_d = olast_q;

    if (ov_q && m_axis_tready_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (cfg_we_i) begin
          base_d  = '0;
          bsh_d   = cfg_wdata_i;
          bcnt_d  = BCN_W'(BW);
          state_d = ST_RED;
        end else if (s_acc) begin
          acc_d   = run_q;
          prod_d  = '0;
          shf_d   = run_q;
          bit_d   = CNT_W'(RW);
          sq_d    = SQ_INIT;
          dl_d    = s_axis_tdata_i[dem_pkg::DIGIT_W-1:0];
          last_d  = s_axis_tlast_i;
          state_d = ST_MUL;
        end
      end
      ST_RED: begin
        if (cfg_we_i) begin
          // restart on a fresh write
          base_d = '0;
          bsh_d  = cfg_wdata_i;
          bcnt_d = BCN_W'(BW);
        end else begin
          base_d = bstep;
          bsh_d  = {bsh_q[BW-2:0], 1'b0};
          bcnt_d = bcnt_q - BCN_W'(1);
          if (bcnt_q == BCN_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_MUL: begin
        prod_d = step;
        shf_d  = {shf_q[RW-2:0], 1'b0};
        bit_d  = bit_q - CNT_W'(1);
        if (bit_q == CNT_W'(1)) begin
          // product done: advance to the next one or finish
          acc_d  = step;
          sq_d   = sq_n;
          dl_d   = dl_n;
          prod_d = '0;
          shf_d  = step;
          bit_d  = CNT_W'(RW);
          if (sq_n == 4'd0 && dl_n == 4'd0) begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (!ov_q || m_axis_tready_i) begin
          ov_d    = 1'b1;
          ores_d  = acc_q;
          olast_d = last_q;
          run_d   = last_q ? ONE_R : acc_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      run_q   <= ONE_R;
      base_q  <= ONE_R;
      bcnt_q  <= '0;
      bit_q   <= '0;
      sq_q    <= '0;
      dl_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      run_q   <= run_d;
      base_q  <= base_d;
      bcnt_q  <= bcnt_d;
      bit_q   <= bit_d;
      sq_q    <= sq_d;
      dl_q    <= dl_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bsh_q   <= bsh_d;
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    shf_q   <= shf_d;
    last_q  <= last_d;
    ores_q  <= ores_d;
    olast_q <= olast_d;
  end

  // Accepted item always starts the multiplier
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !cfg_we_i |=> state_q == ST_MUL)
    else $error("accepted item did not start the multiplier");

  // Residues stay reduced
  a_run_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q < RW'(dem_pkg::MODULUS))
    else $error("running residue not reduced");

  a_base_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_RED |-> base_q < RW'(dem_pkg::MODULUS))
    else $error("base not reduced");

  // A waiting result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !m_axis_tready_i |=> ov_q && $stable(ores_q) && $stable(olast_q))
    else $error("pending result overwritten");

  // Bit counter stays within one multiplier width while multiplying
  a_bit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> bit_q != '0 && bit_q <= CNT_W'(RW))
    else $error("bit counter out of range");

endmodule

`default_nettype wire
